FILE: rtl/joystick_drive_command_conditioner_defines.svh
// ---------------------------------------------------------------------------
// Joystick drive command conditioner assertion macros
// Shared macros for the concurrent checks of the conditioner.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_DRIVE_COMMAND_CONDITIONER_DEFINES_SVH
`define JOYSTICK_DRIVE_COMMAND_CONDITIONER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("joystick conditioner check failed");

// The consequent must hold in the cycle after the antecedent.
`define JDCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("joystick conditioner check failed");

`endif

FILE: rtl/jdcc_pkg.sv
// ---------------------------------------------------------------------------
// Joystick drive command conditioner package
// Widths, register indices, beep codes, request and response types and the
// velocity saturation function.
// ---------------------------------------------------------------------------
`default_nettype none

package jdcc_pkg;

  localparam int unsigned CSU_W = 36;
  localparam int unsigned VEL_W = 23;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 23'sh3FFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 23'sh400000;
  localparam logic [31:0] VEL_NEG_LIMIT = 32'd4194304;
  localparam logic [31:0] VEL_POS_LIMIT = 32'd4194303;

  localparam logic [2:0] CFG_DEADBAND_RADIUS     = 3'd0;
  localparam logic [2:0] CFG_SPIN_DEADBAND       = 3'd1;
  localparam logic [2:0] CFG_SLOW_GAIN_SHIFT     = 3'd2;
  localparam logic [2:0] CFG_FAST_GAIN_SHIFT     = 3'd3;
  localparam logic [2:0] CFG_SPIN_GAIN_SHIFT     = 3'd4;
  localparam logic [2:0] CFG_TOGGLE_HOLDOFF_MS   = 3'd5;
  localparam logic [2:0] CFG_CORRECT_DURATION_MS = 3'd6;

  localparam logic [14:0] RST_DEADBAND_RADIUS     = 15'd100;
  localparam logic [14:0] RST_SPIN_DEADBAND       = 15'd100;
  localparam logic [4:0]  RST_SLOW_GAIN_SHIFT     = 5'd11;
  localparam logic [4:0]  RST_FAST_GAIN_SHIFT     = 5'd10;
  localparam logic [4:0]  RST_SPIN_GAIN_SHIFT     = 5'd10;
  localparam logic [15:0] RST_TOGGLE_HOLDOFF_MS   = 16'd500;
  localparam logic [15:0] RST_CORRECT_DURATION_MS = 16'd1100;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_SLOW = 2'd1;
  localparam logic [1:0] BEEP_FAST = 2'd2;

  typedef struct packed {
    logic        start;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic        neg_x;
    logic        neg_y;
    logic [14:0] radius;
    logic [4:0]  gain_shift;
  } rad_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } rad_rsp_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic neg, input logic [31:0] mag);
    logic signed [VEL_W-1:0] res;
    if (neg) begin
      if (mag > VEL_NEG_LIMIT) begin
        res = VEL_MIN;
      end else begin
        res = VEL_W'(~mag[VEL_W-1:0] + 1'b1);
      end
    end else begin
      if (mag > VEL_POS_LIMIT) begin
        res = VEL_MAX;
      end else begin
        res = mag[VEL_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jdcc_csu.sv
// ---------------------------------------------------------------------------
// Compare-subtract unit
// Shared step of the square root and the division: difference and the flag
// that the first operand is not below the second.
// ---------------------------------------------------------------------------
`default_nettype none

module jdcc_csu (
  input  wire logic [jdcc_pkg::CSU_W-1:0] a_i,
  input  wire logic [jdcc_pkg::CSU_W-1:0] b_i,
  output logic      [jdcc_pkg::CSU_W-1:0] diff_o,
  output logic                            ge_o
);

  logic [jdcc_pkg::CSU_W:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = sub[jdcc_pkg::CSU_W-1:0];
  assign ge_o   = ~sub[jdcc_pkg::CSU_W];

endmodule

`default_nettype wire

FILE: rtl/jdcc_radial.sv
// ---------------------------------------------------------------------------
// Radial deadband sequencer
// Squares the stick axes and, if the length is outside the deadband radius,
// takes it by a bit-pair square root, then scales each axis by a restoring
// division, all on one shared compare-subtract unit and one multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module jdcc_radial (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire jdcc_pkg::rad_req_t req_i,
  input  wire logic               ack_i,
  output jdcc_pkg::rad_rsp_t      rsp_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SQR   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DLOAD = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam int unsigned CW = jdcc_pkg::CSU_W;
  localparam int unsigned VW = jdcc_pkg::VEL_W;

  logic [3:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        axis_q, axis_d;

  logic [15:0] ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [14:0] r_q;
  logic [4:0]  g_q;
  logic [47:0] prod_q;
  logic [31:0] s_q, s_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [31:0] sh_q, sh_d;
  logic [31:0] len_q, len_d;
  logic [31:0] diff_q, diff_d;
  logic [31:0] quo_q, quo_d;
  logic signed [VW-1:0] velx_q, velx_d, vely_q, vely_d;

  logic [15:0]   mul_a;
  logic [31:0]   mul_b;
  logic [CW-1:0] csu_a, csu_b, csu_diff;
  logic          csu_ge;
  logic [31:0]   quo_next;
  logic [31:0]   mag_scaled;
  logic signed [VW-1:0] vel_axis;

  jdcc_csu u_csu (
    .a_i    (csu_a),
    .b_i    (csu_b),
    .diff_o (csu_diff),
    .ge_o   (csu_ge)
  );

  always_comb begin
    mul_a = ax_q;
    mul_b = {16'h0, ax_q};
    case (state_q)
      S_SQY: begin
        mul_a = ay_q;
        mul_b = {16'h0, ay_q};
      end
      S_SQR: begin
        mul_a = {1'b0, r_q};
        mul_b = {17'h0, r_q};
      end
      S_MUL: begin
        mul_a = axis_q ? ay_q : ax_q;
        mul_b = diff_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    csu_a = '0;
    csu_b = '0;
    case (state_q)
      S_CMP: begin
        csu_a = CW'(prod_q[31:0]);
        csu_b = CW'(s_q);
      end
      S_SQRT: begin
        csu_a = {rem_q[CW-3:0], sh_q[31:30]};
        csu_b = CW'({root_q, 2'b01});
      end
      S_DIFF: begin
        csu_a = CW'(root_q);
        csu_b = CW'({r_q, 16'h0});
      end
      S_DIV: begin
        csu_a = CW'({rem_q[31:0], sh_q[31]});
        csu_b = CW'(len_q);
      end
      default: begin
      end
    endcase
  end

  assign quo_next   = {quo_q[30:0], csu_ge};
  assign mag_scaled = quo_next >> g_q;
  assign vel_axis   = jdcc_pkg::sat_vel(axis_q ? negy_q : negx_q, mag_scaled);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    s_d     = s_q;
    rem_d   = rem_q;
    root_d  = root_q;
    sh_d    = sh_q;
    len_d   = len_q;
    diff_d  = diff_q;
    quo_d   = quo_q;
    velx_d  = velx_q;
    vely_d  = vely_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          velx_d  = '0;
          vely_d  = '0;
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        state_d = S_SQY;
      end
      S_SQY: begin
        s_d     = prod_q[31:0];
        state_d = S_SQR;
      end
      S_SQR: begin
        s_d     = s_q + prod_q[31:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        if (csu_ge) begin
          state_d = S_DONE;
        end else begin
          rem_d   = '0;
          root_d  = '0;
          sh_d    = s_q;
          cnt_d   = 5'd31;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        rem_d  = csu_ge ? csu_diff : csu_a;
        root_d = {root_q[30:0], csu_ge};
        sh_d   = {sh_q[29:0], 2'b00};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_d  = csu_diff[31:0];
        len_d   = root_q;
        axis_d  = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        rem_d   = CW'(prod_q[47:16]);
        sh_d    = {prod_q[15:0], 16'h0};
        quo_d   = '0;
        cnt_d   = 5'd31;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = csu_ge ? csu_diff : csu_a;
        quo_d = quo_next;
        sh_d  = {sh_q[30:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          if (axis_q) begin
            vely_d  = vel_axis;
            state_d = S_DONE;
          end else begin
            velx_d  = vel_axis;
            axis_d  = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      ax_q   <= req_i.mag_x;
      ay_q   <= req_i.mag_y;
      negx_q <= req_i.neg_x;
      negy_q <= req_i.neg_y;
      r_q    <= req_i.radius;
      g_q    <= req_i.gain_shift;
    end
    prod_q <= {32'h0, mul_a} * {16'h0, mul_b};
    s_q    <= s_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sh_q   <= sh_d;
    len_q  <= len_d;
    diff_q <= diff_d;
    quo_q  <= quo_d;
    velx_q <= velx_d;
    vely_q <= vely_d;
  end

  assign rsp_o.done  = (state_q == S_DONE);
  assign rsp_o.vel_x = velx_q;
  assign rsp_o.vel_y = vely_q;

endmodule

`default_nettype wire

FILE: rtl/joystick_drive_command_conditioner.sv
// ---------------------------------------------------------------------------
// Joystick drive command conditioner
// One tick at a time: in_stall_o stays high from acceptance until the result
// is registered for output, after 96 compare-subtract steps outside the deadband.
// Reset clears speed mode, toggle and correction state and loads the defaults.
// ---------------------------------------------------------------------------
`default_nettype none

`include "joystick_drive_command_conditioner_defines.svh"

module joystick_drive_command_conditioner (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,

  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] stick_left_x_i,
  input  wire logic signed [15:0] stick_left_y_i,
  input  wire logic signed [15:0] stick_right_x_i,
  input  wire logic               speed_button_i,
  input  wire logic               correct_button_i,
  input  wire logic [31:0]        now_ms_i,

  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [22:0]      vel_x_o,
  output logic signed [22:0]      vel_y_o,
  output logic signed [22:0]      vel_rot_o,
  output logic                    fast_mode_o,
  output logic [1:0]              beep_count_o,
  output logic                    in_correction_o,
  output logic [31:0]             correct_elapsed_ms_o
);

  localparam int unsigned VW = jdcc_pkg::VEL_W;

  logic [14:0] radius_q;
  logic [14:0] spin_db_q;
  logic [4:0]  slow_shift_q;
  logic [4:0]  fast_shift_q;
  logic [4:0]  spin_shift_q;
  logic [15:0] holdoff_q;
  logic [15:0] duration_q;

  logic        mode_q, mode_d;
  logic [31:0] last_toggle_q, last_toggle_d;
  logic        corr_flag_q, corr_flag_d;
  logic [31:0] corr_start_q, corr_start_d;
  logic        busy_q;
  logic        out_valid_q;

  logic signed [VW-1:0] pend_rot_q, pend_rot_d;
  logic [1:0]           pend_beep_q, pend_beep_d;
  logic                 pend_corr_q, pend_corr_d;
  logic [31:0]          pend_elapsed_q, pend_elapsed_d;

  logic signed [VW-1:0] vel_x_q, vel_y_q, vel_rot_q;
  logic                 fast_mode_q;
  logic [1:0]           beep_q;
  logic                 corr_q;
  logic [31:0]          elapsed_q;

  logic               in_accept;
  logic               cfg_accept;
  logic               rad_ack;
  jdcc_pkg::rad_req_t rad_req;
  jdcc_pkg::rad_rsp_t rad_rsp;

  logic [15:0] mag_lx, mag_ly, mag_rx;
  logic [15:0] rot_excess;
  logic [31:0] rot_scaled;
  logic [31:0] holdoff_end;
  logic        toggle;
  logic        corr_start;
  logic        corr_active;
  logic [31:0] corr_start_ms;
  logic [31:0] elapsed;
  logic        beep_out;
  logic        beep_fast;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = busy_q;
  assign cfg_ready_o = !busy_q;
  assign rad_ack     = rad_rsp.done && (!out_valid_q || !out_stall_i);

  assign mag_lx = stick_left_x_i[15]  ? 16'(~stick_left_x_i + 16'sd1)  : stick_left_x_i;
  assign mag_ly = stick_left_y_i[15]  ? 16'(~stick_left_y_i + 16'sd1)  : stick_left_y_i;
  assign mag_rx = stick_right_x_i[15] ? 16'(~stick_right_x_i + 16'sd1) : stick_right_x_i;

  always_comb begin
    holdoff_end   = last_toggle_q + {16'h0, holdoff_q};
    toggle        = speed_button_i && (holdoff_end < now_ms_i);
    mode_d        = toggle ? ~mode_q : mode_q;
    last_toggle_d = toggle ? now_ms_i : last_toggle_q;
    if (!toggle) begin
      pend_beep_d = jdcc_pkg::BEEP_NONE;
    end else if (mode_q) begin
      pend_beep_d = jdcc_pkg::BEEP_SLOW;
    end else begin
      pend_beep_d = jdcc_pkg::BEEP_FAST;
    end

    rot_excess = mag_rx - {1'b0, spin_db_q};
    rot_scaled = {rot_excess, 16'h0} >> spin_shift_q;
    if (mag_rx > {1'b0, spin_db_q}) begin
      pend_rot_d = jdcc_pkg::sat_vel(stick_right_x_i[15], rot_scaled);
    end else begin
      pend_rot_d = '0;
    end

    corr_start     = correct_button_i && !corr_flag_q;
    corr_active    = corr_flag_q || corr_start;
    corr_start_ms  = corr_start ? now_ms_i : corr_start_q;
    corr_start_d   = corr_start_ms;
    elapsed        = now_ms_i - corr_start_ms;
    corr_flag_d    = corr_active && !(elapsed > {16'h0, duration_q});
    pend_corr_d    = corr_active;
    pend_elapsed_d = corr_active ? elapsed : 32'h0;
  end

  always_comb begin
    rad_req.start      = in_accept;
    rad_req.mag_x      = mag_lx;
    rad_req.mag_y      = mag_ly;
    rad_req.neg_x      = stick_left_x_i[15];
    rad_req.neg_y      = stick_left_y_i[15];
    rad_req.radius     = radius_q;
    rad_req.gain_shift = mode_d ? fast_shift_q : slow_shift_q;
  end

  jdcc_radial u_radial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rad_req),
    .ack_i  (rad_ack),
    .rsp_o  (rad_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= jdcc_pkg::RST_DEADBAND_RADIUS;
      spin_db_q     <= jdcc_pkg::RST_SPIN_DEADBAND;
      slow_shift_q  <= jdcc_pkg::RST_SLOW_GAIN_SHIFT;
      fast_shift_q  <= jdcc_pkg::RST_FAST_GAIN_SHIFT;
      spin_shift_q  <= jdcc_pkg::RST_SPIN_GAIN_SHIFT;
      holdoff_q     <= jdcc_pkg::RST_TOGGLE_HOLDOFF_MS;
      duration_q    <= jdcc_pkg::RST_CORRECT_DURATION_MS;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        jdcc_pkg::CFG_DEADBAND_RADIUS:     radius_q     <= cfg_data_i[14:0];
        jdcc_pkg::CFG_SPIN_DEADBAND:       spin_db_q    <= cfg_data_i[14:0];
        jdcc_pkg::CFG_SLOW_GAIN_SHIFT:     slow_shift_q <= cfg_data_i[4:0];
        jdcc_pkg::CFG_FAST_GAIN_SHIFT:     fast_shift_q <= cfg_data_i[4:0];
        jdcc_pkg::CFG_SPIN_GAIN_SHIFT:     spin_shift_q <= cfg_data_i[4:0];
        jdcc_pkg::CFG_TOGGLE_HOLDOFF_MS:   holdoff_q    <= cfg_data_i;
        jdcc_pkg::CFG_CORRECT_DURATION_MS: duration_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      last_toggle_q <= '0;
      corr_flag_q   <= 1'b0;
      corr_start_q  <= '0;
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_q        <= mode_d;
        last_toggle_q <= last_toggle_d;
        corr_flag_q   <= corr_flag_d;
        corr_start_q  <= corr_start_d;
        busy_q        <= 1'b1;
      end else if (rad_ack) begin
        busy_q <= 1'b0;
      end
      if (rad_ack) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_rot_q     <= pend_rot_d;
      pend_beep_q    <= pend_beep_d;
      pend_corr_q    <= pend_corr_d;
      pend_elapsed_q <= pend_elapsed_d;
    end
    if (rad_ack) begin
      vel_x_q     <= rad_rsp.vel_x;
      vel_y_q     <= rad_rsp.vel_y;
      vel_rot_q   <= pend_rot_q;
      fast_mode_q <= mode_q;
      beep_q      <= pend_beep_q;
      corr_q      <= pend_corr_q;
      elapsed_q   <= pend_elapsed_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign vel_x_o              = vel_x_q;
  assign vel_y_o              = vel_y_q;
  assign vel_rot_o            = vel_rot_q;
  assign fast_mode_o          = fast_mode_q;
  assign beep_count_o         = beep_q;
  assign in_correction_o      = corr_q;
  assign correct_elapsed_ms_o = elapsed_q;

  assign beep_out  = out_valid_q && (beep_q != jdcc_pkg::BEEP_NONE);
  assign beep_fast = (beep_q == jdcc_pkg::BEEP_FAST);

  `JDCC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, busy_q)
  `JDCC_ASSERT_SAME(a_idle_no_result, clk_i, rst_ni, !busy_q, !rad_rsp.done)
  `JDCC_ASSERT_SAME(a_beep_matches_mode, clk_i, rst_ni, beep_out, fast_mode_q == beep_fast)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// Joystick drive command conditioner testbench
// Drives control ticks through the valid/stall input channel and checks every
// drive command against a typed expectation or a cycle-free model of the stick
// deadbands, gains, speed toggle and correction timer. A directed table comes
// first, then random ticks under several register settings and idling patterns.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jdcc_pkg::*;

  localparam int unsigned DIR_ROWS         = 25;
  localparam int unsigned PHASE_TICKS      = 105;
  localparam int unsigned LONG_HOLD_CYCLES = 600;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;
  localparam bit          TYPED            = 1'b1;
  localparam bit          PREDICTED        = 1'b0;

  typedef struct packed {
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic               speed;
    logic               correct;
    logic [31:0]        now;
  } tick_t;

  typedef struct packed {
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
    logic [VEL_W-1:0] vel_rot;
    logic             fast;
    logic [1:0]       beeps;
    logic             in_corr;
    logic [31:0]      elapsed;
  } drive_result_t;

  typedef struct packed {
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic               speed;
    logic               correct;
    logic [31:0]        now;
    logic               typed;
    logic [VEL_W-1:0]   vel_x;
    logic [VEL_W-1:0]   vel_y;
    logic [VEL_W-1:0]   vel_rot;
    logic               fast;
    logic [1:0]         beeps;
    logic               in_corr;
    logic [31:0]        elapsed;
  } dir_row_t;

  typedef logic [6:0][15:0] reg_set_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_valid_i      = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i      = '0;
  logic [15:0]        cfg_data_i       = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] stick_left_x_i   = '0;
  logic signed [15:0] stick_left_y_i   = '0;
  logic signed [15:0] stick_right_x_i  = '0;
  logic               speed_button_i   = 1'b0;
  logic               correct_button_i = 1'b0;
  logic [31:0]        now_ms_i         = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic signed [22:0] vel_x_o;
  logic signed [22:0] vel_y_o;
  logic signed [22:0] vel_rot_o;
  logic               fast_mode_o;
  logic [1:0]         beep_count_o;
  logic               in_correction_o;
  logic [31:0]        correct_elapsed_ms_o;

  logic [14:0] cf_radius   = RST_DEADBAND_RADIUS;
  logic [14:0] cf_spin_db  = RST_SPIN_DEADBAND;
  logic [4:0]  cf_slow_sh  = RST_SLOW_GAIN_SHIFT;
  logic [4:0]  cf_fast_sh  = RST_FAST_GAIN_SHIFT;
  logic [4:0]  cf_spin_sh  = RST_SPIN_GAIN_SHIFT;
  logic [15:0] cf_holdoff  = RST_TOGGLE_HOLDOFF_MS;
  logic [15:0] cf_duration = RST_CORRECT_DURATION_MS;

  logic        st_fast         = 1'b0;
  logic [31:0] st_last_toggle  = '0;
  logic        st_correcting   = 1'b0;
  logic [31:0] st_correct_from = '0;

  drive_result_t expected_drive_q[$];
  int unsigned   fault_count    = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  logic          long_hold      = 1'b0;
  logic [31:0]   now_cursor     = 32'h20;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd0, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd100, 16'sd0, 16'sd100, 1'b0, 1'b0, 32'd1, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, -16'sd100, -16'sd100, 1'b0, 1'b0, 32'd2, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd70, 16'sd71, 16'sd0, 1'b0, 1'b0, 32'd3, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd71, 16'sd71, 16'sd0, 1'b0, 1'b0, 32'd4, PREDICTED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0, 1'b0, 32'd5, TYPED,
      23'd0, 23'd0, -23'sd2090752, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd32767, 1'b0, 1'b0, 32'd6, TYPED,
      23'd0, 23'd0, 23'sd2090688, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sh8000, 16'sh8000, 16'sd101, 1'b0, 1'b0, 32'd7, PREDICTED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd32767, 16'sd0, -16'sd101, 1'b0, 1'b0, 32'd8, PREDICTED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b0, 1'b0, 32'd9, PREDICTED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 32'd500, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 32'd501, TYPED,
      23'd0, 23'd0, 23'd0, 1'b1, BEEP_FAST, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 32'd1001, TYPED,
      23'd0, 23'd0, 23'd0, 1'b1, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 32'd1002, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_SLOW, 1'b0, 32'd0},
    '{16'sd1000, -16'sd1000, 16'sd5000, 1'b0, 1'b0, 32'd1003, PREDICTED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 32'd2000, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b1, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 32'd3100, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b1, 32'd1100},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd3101, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b1, 32'd1101},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'd3102, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 32'hFFFFFFFF, TYPED,
      23'd0, 23'd0, 23'd0, 1'b1, BEEP_FAST, 1'b0, 32'd0},
    '{16'sd12000, -16'sd9000, -16'sd7000, 1'b1, 1'b0, 32'd100, PREDICTED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 32'd600, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_SLOW, 1'b1, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 32'hFFFFFF00, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b1, 32'hFFFFFCA8},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 32'hFFFFFF00, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b1, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'h10, TYPED,
      23'd0, 23'd0, 23'd0, 1'b0, BEEP_NONE, 1'b1, 32'h110}
  };

  joystick_drive_command_conditioner u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .stick_left_x_i      (stick_left_x_i),
    .stick_left_y_i      (stick_left_y_i),
    .stick_right_x_i     (stick_right_x_i),
    .speed_button_i      (speed_button_i),
    .correct_button_i    (correct_button_i),
    .now_ms_i            (now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .vel_x_o             (vel_x_o),
    .vel_y_o             (vel_y_o),
    .vel_rot_o           (vel_rot_o),
    .fast_mode_o         (fast_mode_o),
    .beep_count_o        (beep_count_o),
    .in_correction_o     (in_correction_o),
    .correct_elapsed_ms_o(correct_elapsed_ms_o)
  );

  always #4ns clk_i = ~clk_i;

  function automatic logic [VEL_W-1:0] clamp_velocity(input bit neg, input logic [63:0] mag);
    if (neg) begin
      return (mag > 64'(VEL_NEG_LIMIT)) ? VEL_MIN : VEL_W'(-mag);
    end
    return (mag > 64'(VEL_POS_LIMIT)) ? VEL_MAX : mag[VEL_W-1:0];
  endfunction

  function automatic drive_result_t condition_tick(input tick_t t);
    drive_result_t res;
    logic [31:0]   toggle_due;
    logic [31:0]   since_start;
    logic [63:0]   ax, ay, sq, rad, root, trial, diff, spin_mag;
    logic [4:0]    shift;
    int            sx, sy, sr, ar;
    res = '0;
    sx = t.lx;
    sy = t.ly;
    sr = t.rx;
    ax = 64'((sx < 0) ? -sx : sx);
    ay = 64'((sy < 0) ? -sy : sy);
    ar = (sr < 0) ? -sr : sr;

    toggle_due = st_last_toggle + 32'(cf_holdoff);
    if (t.speed && (toggle_due < t.now)) begin
      st_last_toggle = t.now;
      st_fast = !st_fast;
      res.beeps = st_fast ? BEEP_FAST : BEEP_SLOW;
    end
    shift = st_fast ? cf_fast_sh : cf_slow_sh;

    sq = ax * ax + ay * ay;
    rad = 64'(cf_radius);
    if (sq > rad * rad) begin
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= (sq << 32)) begin
          root = trial;
        end
      end
      diff = root - (rad << 16);
      res.vel_x = clamp_velocity(sx < 0, (((ax * diff) << 16) / root) >> shift);
      res.vel_y = clamp_velocity(sy < 0, (((ay * diff) << 16) / root) >> shift);
    end

    if (ar > int'(cf_spin_db)) begin
      spin_mag = 64'(ar - int'(cf_spin_db));
      if (int'(cf_spin_sh) <= 16) begin
        spin_mag = spin_mag << (16 - int'(cf_spin_sh));
      end else begin
        spin_mag = spin_mag >> (int'(cf_spin_sh) - 16);
      end
      res.vel_rot = clamp_velocity(sr < 0, spin_mag);
    end

    if (t.correct && !st_correcting) begin
      st_correcting = 1'b1;
      st_correct_from = t.now;
    end
    if (st_correcting) begin
      since_start = t.now - st_correct_from;
      res.in_corr = 1'b1;
      res.elapsed = since_start;
      if (since_start > 32'(cf_duration)) begin
        st_correcting = 1'b0;
      end
    end
    res.fast = st_fast;
    return res;
  endfunction

  function automatic logic signed [15:0] random_axis(input int unsigned centre);
    int v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: begin
        case ($urandom_range(2))
          0: v = -32768;
          1: v = 32767;
          default: v = 0;
        endcase
      end
      2: begin
        v = int'(centre) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
      default: v = int'($urandom_range(8191)) - 4096;
    endcase
    return 16'(v);
  endfunction

  function automatic tick_t make_random_tick();
    tick_t t;
    case ($urandom_range(9))
      0: now_cursor = $urandom;
      1: now_cursor = st_last_toggle + 32'(cf_holdoff) + $urandom_range(1);
      2: now_cursor = st_correct_from + 32'(cf_duration) + $urandom_range(1);
      3: now_cursor = 32'hFFFFFFFF - $urandom_range(1000);
      default: now_cursor = now_cursor + $urandom_range(400);
    endcase
    t.lx = random_axis(cf_radius);
    t.ly = random_axis(cf_radius);
    t.rx = random_axis(cf_spin_db);
    t.speed = ($urandom_range(99) < 35);
    t.correct = ($urandom_range(99) < 20);
    t.now = now_cursor;
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input bit typed, input drive_result_t typed_res);
    drive_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    stick_left_x_i   <= t.lx;
    stick_left_y_i   <= t.ly;
    stick_right_x_i  <= t.rx;
    speed_button_i   <= t.speed;
    correct_button_i <= t.correct;
    now_ms_i         <= t.now;
    do @(posedge clk_i); while (in_stall_o);
    predicted = condition_tick(t);
    expected_drive_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(input reg_set_t regs, input bit poke_unused);
    logic [2:0]  idx;
    logic [15:0] data;
    for (int i = 0; i < (poke_unused ? 8 : 7); i++) begin
      idx = 3'(i);
      if (idx == CFG_UNUSED_INDEX) begin
        data = 16'hFFFF;
      end else begin
        data = regs[idx];
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CFG_DEADBAND_RADIUS:     cf_radius   = data[14:0];
        CFG_SPIN_DEADBAND:       cf_spin_db  = data[14:0];
        CFG_SLOW_GAIN_SHIFT:     cf_slow_sh  = data[4:0];
        CFG_FAST_GAIN_SHIFT:     cf_fast_sh  = data[4:0];
        CFG_SPIN_GAIN_SHIFT:     cf_spin_sh  = data[4:0];
        CFG_TOGGLE_HOLDOFF_MS:   cf_holdoff  = data;
        CFG_CORRECT_DURATION_MS: cf_duration = data;
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_hold);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    if (with_hold) begin
      fork
        begin
          long_hold <= 1'b1;
          repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
          long_hold <= 1'b0;
        end
      join_none
    end
    repeat (PHASE_TICKS) send_tick(make_random_tick(), PREDICTED, '0);
    drain_results();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    drive_result_t seen;
    drive_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen = '{vel_x_o, vel_y_o, vel_rot_o, fast_mode_o, beep_count_o,
                 in_correction_o, correct_elapsed_ms_o};
        if (expected_drive_q.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("Unexpected result transaction: %p", seen);
          end
        end else begin
          want = expected_drive_q.pop_front();
          if (seen !== want) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("Drive command mismatch: expected %p, got %p", want, seen);
            end
          end
        end
      end
      out_stall_i <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    tick_t         t;
    drive_result_t r;
    reg_set_t      regs;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      t = '{directed_rows[i].lx, directed_rows[i].ly, directed_rows[i].rx,
            directed_rows[i].speed, directed_rows[i].correct, directed_rows[i].now};
      r = '{directed_rows[i].vel_x, directed_rows[i].vel_y, directed_rows[i].vel_rot,
            directed_rows[i].fast, directed_rows[i].beeps, directed_rows[i].in_corr,
            directed_rows[i].elapsed};
      send_tick(t, directed_rows[i].typed, r);
    end
    drain_results();

    run_phase(85, 0, 1'b0);

    regs = '0;
    write_settings(regs, 1'b1);
    run_phase(0, 85, 1'b0);

    regs = '1;
    write_settings(regs, 1'b0);
    run_phase(32, 32, 1'b0);

    regs[CFG_DEADBAND_RADIUS]     = 16'($urandom_range(3000));
    regs[CFG_SPIN_DEADBAND]       = 16'($urandom_range(3000));
    regs[CFG_SLOW_GAIN_SHIFT]     = 16'($urandom_range(16));
    regs[CFG_FAST_GAIN_SHIFT]     = 16'($urandom_range(16));
    regs[CFG_SPIN_GAIN_SHIFT]     = 16'($urandom_range(16));
    regs[CFG_TOGGLE_HOLDOFF_MS]   = 16'($urandom_range(300));
    regs[CFG_CORRECT_DURATION_MS] = 16'($urandom_range(300));
    write_settings(regs, 1'b0);
    run_phase(0, 0, 1'b1);

    regs[CFG_DEADBAND_RADIUS]     = 16'($urandom_range(20000));
    regs[CFG_SPIN_DEADBAND]       = 16'($urandom);
    regs[CFG_SLOW_GAIN_SHIFT]     = 16'($urandom);
    regs[CFG_FAST_GAIN_SHIFT]     = 16'($urandom);
    regs[CFG_SPIN_GAIN_SHIFT]     = 16'($urandom);
    regs[CFG_TOGGLE_HOLDOFF_MS]   = 16'($urandom);
    regs[CFG_CORRECT_DURATION_MS] = 16'($urandom);
    write_settings(regs, 1'b0);
    run_phase(32, 32, 1'b0);

    regs[CFG_DEADBAND_RADIUS]     = 16'(RST_DEADBAND_RADIUS);
    regs[CFG_SPIN_DEADBAND]       = 16'(RST_SPIN_DEADBAND);
    regs[CFG_SLOW_GAIN_SHIFT]     = 16'(RST_SLOW_GAIN_SHIFT);
    regs[CFG_FAST_GAIN_SHIFT]     = 16'(RST_FAST_GAIN_SHIFT);
    regs[CFG_SPIN_GAIN_SHIFT]     = 16'(RST_SPIN_GAIN_SHIFT);
    regs[CFG_TOGGLE_HOLDOFF_MS]   = RST_TOGGLE_HOLDOFF_MS;
    regs[CFG_CORRECT_DURATION_MS] = RST_CORRECT_DURATION_MS;
    write_settings(regs, 1'b0);
    run_phase(0, 85, 1'b0);

    repeat (120) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("joystick_drive_command_conditioner regression: pass");
    end else begin
      $display("joystick_drive_command_conditioner regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("joystick_drive_command_conditioner regression: fail");
    $finish;
  end

endmodule
